>>> sv/fsa_pkg.sv
// Shared types and constants for the fixed-step accumulator.
`timescale 1ns / 1ps

package fsa_pkg;

    // Width of the step count and of the substep limit register.
    localparam int unsigned COUNT_WIDTH = 16;

    // Register reset values.
    localparam logic [63:0] STEP_TICKS_RESET    = 64'd16667;
    localparam logic [63:0] MAX_ACC_TICKS_RESET = 64'd250000;
    localparam logic [COUNT_WIDTH-1:0] MAX_SUBSTEPS_RESET = 16'd8;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_STEP_TICKS    = 2'd0;
    localparam logic [1:0] REG_MAX_ACC_TICKS = 2'd1;
    localparam logic [1:0] REG_MAX_SUBSTEPS  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP,
        ST_ADD,
        ST_DIV,
        ST_CLAMP,
        ST_MUL,
        ST_APPLY,
        ST_FRAC_INIT,
        ST_FRAC,
        ST_DONE
    } state_t;

endpackage

>>> sv/fixed_step_accumulator_core.sv
// Fixed-step time accumulator: sequencer, shared compare/subtract unit and registers.
`timescale 1ns / 1ps

// Usage
// The input channel (s_valid, s_ready, s_frame_delta) takes one item per rendered
// frame, carrying the frame duration in ticks. The result channel (m_valid, m_ready,
// m_*) returns exactly one item for each input item, in order.
// Configuration (step length, accumulator cap, substep limit) is written through the
// APB-style port, by the user only while the block is idle; the block itself does
// not enforce this. pready is always high.
// The fraction pass is skipped when the retained time is a full step or more, or
// when the step length is zero.
// The block works on one item at a time: a new item is accepted only in the idle
// state, after the previous result has left the sequencer. The pace is set by the
// single shared compare/subtract unit, which runs the quotient (one bit per cycle)
// and the fraction (one fraction bit per cycle), and by the shift-add multiplier
// (one count bit per cycle).
// The output register parts the two sides: a new item is accepted while a finished
// result still waits. If the receiver stalls, the next result is held in the
// sequencer until the output register frees up.
// Reset (aresetn low at a clock edge) clears the accumulator and elapsed time,
// restores the register reset values and empties the output register.
module fixed_step_accumulator_core #(
    parameter int unsigned TIME_WIDTH    = 32,
    parameter int unsigned ELAPSED_WIDTH = 48,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [(TIME_WIDTH > 32 ? 5 : 4)-1:0]  paddr,
    input  logic [(TIME_WIDTH > 32 ? 64 : 32)-1:0] pwdata,
    output logic [(TIME_WIDTH > 32 ? 64 : 32)-1:0] prdata,
    output logic                                  pready,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [TIME_WIDTH-1:0]                 s_frame_delta,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [fsa_pkg::COUNT_WIDTH-1:0]       m_step_count,
    output logic [ELAPSED_WIDTH-1:0]              m_first_step_time,
    output logic [TIME_WIDTH-1:0]                 m_dropped_ticks,
    output logic [TIME_WIDTH-1:0]                 m_retained_ticks,
    output logic [FRACTION_BITS:0]                m_blend_fraction
);

    import fsa_pkg::*;

    localparam int unsigned DATA_WIDTH = (TIME_WIDTH > 32) ? 64 : 32;
    localparam int unsigned ADDR_LSB   = (TIME_WIDTH > 32) ? 3 : 2;
    localparam int unsigned PROD_WIDTH = TIME_WIDTH + COUNT_WIDTH;
    localparam int unsigned CMP_WIDTH  = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
    localparam int unsigned MAX_ITER_A = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
    localparam int unsigned MAX_ITER   = (MAX_ITER_A > FRACTION_BITS) ? MAX_ITER_A
                                                                      : FRACTION_BITS;
    localparam int unsigned ITER_WIDTH = $clog2(MAX_ITER);

    localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // Configuration registers.
    logic [TIME_WIDTH-1:0]  step_reg;
    logic [TIME_WIDTH-1:0]  max_acc_reg;
    logic [COUNT_WIDTH-1:0] max_sub_reg;
    logic                   cfg_write;
    logic [1:0]             cfg_index;

    // Sequencer and datapath registers.
    state_t                   state_reg, state_next;
    logic [ITER_WIDTH-1:0]    iter_reg, iter_next;
    logic [TIME_WIDTH-1:0]    delta_reg, delta_next;
    logic [TIME_WIDTH-1:0]    cap_reg, cap_next;
    logic [TIME_WIDTH-1:0]    dropped_reg, dropped_next;
    logic [TIME_WIDTH-1:0]    acc_reg, acc_next;
    logic [ELAPSED_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [ELAPSED_WIDTH-1:0] first_reg, first_next;
    logic [TIME_WIDTH-1:0]    quo_reg, quo_next;
    logic [TIME_WIDTH-1:0]    rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic [COUNT_WIDTH-1:0]   mult_reg, mult_next;
    logic [PROD_WIDTH-1:0]    mcand_reg, mcand_next;
    logic [PROD_WIDTH-1:0]    prod_reg, prod_next;
    logic [FRACTION_BITS:0]   frac_reg, frac_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0]   out_count_reg, out_count_next;
    logic [ELAPSED_WIDTH-1:0] out_first_reg, out_first_next;
    logic [TIME_WIDTH-1:0]    out_dropped_reg, out_dropped_next;
    logic [TIME_WIDTH-1:0]    out_retained_reg, out_retained_next;
    logic [FRACTION_BITS:0]   out_frac_reg, out_frac_next;

    // Shared compare/subtract unit: trial value against the step length.
    logic [TIME_WIDTH:0]   trial;
    logic [TIME_WIDTH+1:0] trial_diff;
    logic                  trial_ge;

    // Other datapath terms.
    logic [TIME_WIDTH:0]   cap_diff;
    logic                  delta_lt_cap;
    logic                  step_zero;
    logic                  quo_above_limit;

    // ------------------------------------------------------------------
    // Configuration port. A write lands on the access cycle; unused
    // addresses are ignored and read as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[ADDR_LSB +: 2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= TIME_WIDTH'(STEP_TICKS_RESET);
            max_acc_reg <= TIME_WIDTH'(MAX_ACC_TICKS_RESET);
            max_sub_reg <= MAX_SUBSTEPS_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_STEP_TICKS: begin
                    step_reg <= TIME_WIDTH'(pwdata);
                end
                REG_MAX_ACC_TICKS: begin
                    max_acc_reg <= TIME_WIDTH'(pwdata);
                end
                REG_MAX_SUBSTEPS: begin
                    max_sub_reg <= pwdata[COUNT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_STEP_TICKS:    prdata = DATA_WIDTH'(step_reg);
            REG_MAX_ACC_TICKS: prdata = DATA_WIDTH'(max_acc_reg);
            REG_MAX_SUBSTEPS:  prdata = DATA_WIDTH'(max_sub_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared unit. During the quotient the next dividend bit is shifted
    // into the partial remainder; during the fraction the remainder is
    // doubled; before the fraction it checks for a full step retained.
    // ------------------------------------------------------------------
    always_comb begin
        case (state_reg)
            ST_DIV:  trial = {rem_reg, quo_reg[TIME_WIDTH-1]};
            ST_FRAC: trial = {rem_reg, 1'b0};
            default: trial = {1'b0, acc_reg};
        endcase
    end

    assign trial_diff = {1'b0, trial} - {2'b00, step_reg};
    assign trial_ge   = ~trial_diff[TIME_WIDTH+1];

    assign cap_diff        = {1'b0, max_acc_reg} - {1'b0, acc_reg};
    assign delta_lt_cap    = delta_reg < cap_reg;
    assign step_zero       = (step_reg == '0);
    assign quo_above_limit = CMP_WIDTH'(quo_reg) > CMP_WIDTH'(max_sub_reg);

    assign s_ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates.
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        iter_next         = iter_reg;
        delta_next        = delta_reg;
        cap_next          = cap_reg;
        dropped_next      = dropped_reg;
        acc_next          = acc_reg;
        elapsed_next      = elapsed_reg;
        first_next        = first_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        count_next        = count_reg;
        mult_next         = mult_reg;
        mcand_next        = mcand_reg;
        prod_next         = prod_reg;
        frac_next         = frac_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_count_next    = out_count_reg;
        out_first_next    = out_first_reg;
        out_dropped_next  = out_dropped_reg;
        out_retained_next = out_retained_reg;
        out_frac_next     = out_frac_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    delta_next = s_frame_delta;
                    state_next = ST_CAP;
                end
            end
            ST_CAP: begin
                // Room left under the cap; none when the cap was lowered below
                // the current accumulator.
                cap_next   = cap_diff[TIME_WIDTH] ? '0 : cap_diff[TIME_WIDTH-1:0];
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (delta_lt_cap) begin
                    acc_next     = acc_reg + delta_reg;
                    dropped_next = '0;
                end else begin
                    acc_next     = acc_reg + cap_reg;
                    dropped_next = delta_reg - cap_reg;
                end
                quo_next   = acc_next;
                rem_next   = '0;
                iter_next  = ITER_WIDTH'(TIME_WIDTH - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = trial_ge ? trial_diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
                quo_next = {quo_reg[TIME_WIDTH-2:0], trial_ge};
                if (iter_reg == '0) begin
                    state_next = ST_CLAMP;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_CLAMP: begin
                if (step_zero) begin
                    count_next = '0;
                end else if (quo_above_limit) begin
                    count_next = max_sub_reg;
                end else begin
                    count_next = COUNT_WIDTH'(quo_reg);
                end
                mult_next  = count_next;
                mcand_next = PROD_WIDTH'(step_reg);
                prod_next  = '0;
                iter_next  = ITER_WIDTH'(COUNT_WIDTH - 1);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mult_reg[0]) begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[PROD_WIDTH-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[COUNT_WIDTH-1:1]};
                if (iter_reg == '0) begin
                    state_next = ST_APPLY;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_APPLY: begin
                // The executed time never exceeds the accumulator.
                acc_next     = acc_reg - prod_reg[TIME_WIDTH-1:0];
                elapsed_next = elapsed_reg + ELAPSED_WIDTH'(prod_reg);
                if (count_reg != '0) begin
                    first_next = elapsed_reg + ELAPSED_WIDTH'(step_reg);
                end else begin
                    first_next = elapsed_reg;
                end
                state_next = ST_FRAC_INIT;
            end
            ST_FRAC_INIT: begin
                if (step_zero) begin
                    frac_next  = (acc_reg != '0) ? FRAC_ONE : '0;
                    state_next = ST_DONE;
                end else if (trial_ge) begin
                    // A full step or more is left over: the fraction saturates.
                    frac_next  = FRAC_ONE;
                    state_next = ST_DONE;
                end else begin
                    frac_next  = '0;
                    rem_next   = acc_reg;
                    iter_next  = ITER_WIDTH'(FRACTION_BITS - 1);
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                rem_next  = trial_ge ? trial_diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
                frac_next = {frac_reg[FRACTION_BITS-1:0], trial_ge};
                if (iter_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next    = 1'b1;
                    out_count_next    = count_reg;
                    out_first_next    = first_reg;
                    out_dropped_next  = dropped_reg;
                    out_retained_next = acc_reg;
                    out_frac_next     = frac_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            elapsed_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg         <= iter_next;
        delta_reg        <= delta_next;
        cap_reg          <= cap_next;
        dropped_reg      <= dropped_next;
        first_reg        <= first_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        count_reg        <= count_next;
        mult_reg         <= mult_next;
        mcand_reg        <= mcand_next;
        prod_reg         <= prod_next;
        frac_reg         <= frac_next;
        out_count_reg    <= out_count_next;
        out_first_reg    <= out_first_next;
        out_dropped_reg  <= out_dropped_next;
        out_retained_reg <= out_retained_next;
        out_frac_reg     <= out_frac_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_step_count      = out_count_reg;
    assign m_first_step_time = out_first_reg;
    assign m_dropped_ticks   = out_dropped_reg;
    assign m_retained_ticks  = out_retained_reg;
    assign m_blend_fraction  = out_frac_reg;

endmodule

>>> verif/fsa_frame_checker.sv
// Frame result checker for the fixed-step accumulator: watches both channels and the register port.
`timescale 1ns / 1ps

module fsa_frame_checker #(
    parameter int unsigned TIME_WIDTH    = 32,
    parameter int unsigned ELAPSED_WIDTH = 48,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,

    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [TIME_WIDTH-1:0]           s_frame_delta,

    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [fsa_pkg::COUNT_WIDTH-1:0] m_step_count,
    input  logic [ELAPSED_WIDTH-1:0]        m_first_step_time,
    input  logic [TIME_WIDTH-1:0]           m_dropped_ticks,
    input  logic [TIME_WIDTH-1:0]           m_retained_ticks,
    input  logic [FRACTION_BITS:0]          m_blend_fraction,

    output int                              mismatch_count,
    output int                              open_results
);
    import fsa_pkg::*;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]   steps;
        logic [ELAPSED_WIDTH-1:0] first_time;
        logic [TIME_WIDTH-1:0]    dropped;
        logic [TIME_WIDTH-1:0]    retained;
        logic [FRACTION_BITS:0]   blend;
    } frame_result_t;

    // Register copies and timeline state.
    logic [TIME_WIDTH-1:0]    step_len;
    logic [TIME_WIDTH-1:0]    acc_cap;
    logic [COUNT_WIDTH-1:0]   substep_cap;
    logic [TIME_WIDTH-1:0]    acc_ticks;
    logic [ELAPSED_WIDTH-1:0] sim_clock;

    frame_result_t expected_frames[$];
    int            bad_fields = 0;
    int            frames_checked = 0;

    assign mismatch_count = bad_fields;

    // Advances the timeline by one frame and returns what the block should report.
    function automatic frame_result_t predict_frame(input logic [TIME_WIDTH-1:0] delta);
        frame_result_t r;
        logic [63:0]   room;
        logic [63:0]   taken;
        logic [63:0]   acc;
        logic [63:0]   count;
        logic [63:0]   rem;
        logic [63:0]   quo;
        logic [63:0]   den;
        room  = (acc_cap > acc_ticks) ? 64'(acc_cap) - 64'(acc_ticks) : 64'd0;
        taken = (64'(delta) < room) ? 64'(delta) : room;
        acc   = 64'(acc_ticks) + taken;
        den   = 64'(step_len);
        count = 0;
        if (den != 0) begin
            count = acc / den;
            if (count > 64'(substep_cap))
                count = 64'(substep_cap);
        end
        r.first_time = sim_clock;
        if (count != 0) begin
            acc          = acc - count * den;
            r.first_time = sim_clock + ELAPSED_WIDTH'(den);
            sim_clock    = sim_clock + ELAPSED_WIDTH'(count * den);
        end
        if (den == 0) begin
            r.blend = (acc != 0) ? (FRACTION_BITS+1)'(1) << FRACTION_BITS : '0;
        end else if (acc >= den) begin
            r.blend = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
        end else begin
            // Restoring division, one fraction bit per pass, without overflowing 2*rem.
            rem = acc;
            quo = 0;
            for (int i = 0; i < FRACTION_BITS; i++) begin
                quo = quo << 1;
                if (rem >= den - rem) begin
                    rem = rem - (den - rem);
                    quo = quo | 64'd1;
                end else begin
                    rem = rem << 1;
                end
            end
            r.blend = (FRACTION_BITS+1)'(quo);
        end
        acc_ticks  = TIME_WIDTH'(acc);
        r.steps    = COUNT_WIDTH'(count);
        r.dropped  = TIME_WIDTH'(64'(delta) - taken);
        r.retained = TIME_WIDTH'(acc);
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("%0t ns: frame %0d %s: got 0x%0h, expected 0x%0h",
                 $time, frames_checked, what, got, want);
        bad_fields++;
    endtask

    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            step_len    = STEP_TICKS_RESET[TIME_WIDTH-1:0];
            acc_cap     = MAX_ACC_TICKS_RESET[TIME_WIDTH-1:0];
            substep_cap = MAX_SUBSTEPS_RESET;
            acc_ticks   = '0;
            sim_clock   = '0;
            expected_frames.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_STEP_TICKS:    step_len    = TIME_WIDTH'(pwdata);
                    REG_MAX_ACC_TICKS: acc_cap     = TIME_WIDTH'(pwdata);
                    REG_MAX_SUBSTEPS:  substep_cap = pwdata[COUNT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_frames.push_back(predict_frame(s_frame_delta));
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    log_mismatch("unexpected result", 64'(m_step_count), 64'd0);
                end else begin
                    want = expected_frames.pop_front();
                    if (m_step_count !== want.steps)
                        log_mismatch("step_count", 64'(m_step_count), 64'(want.steps));
                    if (m_first_step_time !== want.first_time)
                        log_mismatch("first_step_time", 64'(m_first_step_time),
                                     64'(want.first_time));
                    if (m_dropped_ticks !== want.dropped)
                        log_mismatch("dropped_ticks", 64'(m_dropped_ticks), 64'(want.dropped));
                    if (m_retained_ticks !== want.retained)
                        log_mismatch("retained_ticks", 64'(m_retained_ticks),
                                     64'(want.retained));
                    if (m_blend_fraction !== want.blend)
                        log_mismatch("blend_fraction", 64'(m_blend_fraction), 64'(want.blend));
                end
                frames_checked++;
            end
        end
        open_results <= expected_frames.size();
    end

endmodule

>>> verif/fixed_step_accumulator_core_test.sv
// Top of the fixed-step accumulator testbench: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps

module fixed_step_accumulator_core_test;
    import fsa_pkg::*;

    // Register index with no register behind it; writes there must be ignored.
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Cycles without any accepted item or register access before the run is declared hung.
    // The slowest correct stretch is the long receiver hold plus one item in flight and
    // the idle draws on both sides, so this leaves wide margin.
    localparam int QUIET_LIMIT = 3000;
    // The long receiver hold that lets the block fill up and push back on its input.
    localparam int LONG_HOLD = 400;
    // Cycles to let pass after the last result, a bit beyond one item's latency.
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_FRAMES = 240;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_frame_delta = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_step_count;
    logic [47:0] m_first_step_time;
    logic [31:0] m_dropped_ticks;
    logic [31:0] m_retained_ticks;
    logic [16:0] m_blend_fraction;

    int          mismatch_count;
    int          open_results;

    // The test keeps its own idea of the step length only to aim frame durations
    // near step boundaries; the checker owns the real prediction.
    logic [31:0] aim_step = 32'd16667;
    logic        send_burst = 1'b0;
    logic        sink_burst = 1'b0;
    int          results_taken = 0;
    int          quiet_cycles = 0;

    fixed_step_accumulator_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_frame_delta     (s_frame_delta),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_step_count      (m_step_count),
        .m_first_step_time (m_first_step_time),
        .m_dropped_ticks   (m_dropped_ticks),
        .m_retained_ticks  (m_retained_ticks),
        .m_blend_fraction  (m_blend_fraction)
    );

    fsa_frame_checker frame_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_frame_delta     (s_frame_delta),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_step_count      (m_step_count),
        .m_first_step_time (m_first_step_time),
        .m_dropped_ticks   (m_dropped_ticks),
        .m_retained_ticks  (m_retained_ticks),
        .m_blend_fraction  (m_blend_fraction),
        .mismatch_count    (mismatch_count),
        .open_results      (open_results)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle draw for either side. Burst mode gives long runs with no idling at all,
    // and the mode flips now and then so that both kinds of stretch occur.
    function automatic int idle_draw(inout logic burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // Stops offering input and waits until every expected result has come back, so
    // the block is idle. The checker's count is registered, so sampling after an
    // edge is safe.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_results != 0);
    endtask

    // One register write: setup cycle, then access cycle; the register takes the
    // value at the edge that ends the access cycle. A dead cycle follows, so that
    // back-to-back writes never lower and raise psel in the same step.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Loads all three registers. The substep limit is written with junk in the
    // upper half, which the block must drop.
    task automatic load_settings(input logic [31:0] step, input logic [31:0] cap,
                                 input logic [15:0] substeps);
        write_reg(REG_STEP_TICKS, step);
        write_reg(REG_MAX_ACC_TICKS, cap);
        write_reg(REG_MAX_SUBSTEPS, {16'($urandom), substeps});
        aim_step = step;
    endtask

    // Offers one frame duration and returns at the edge where it was taken.
    // Valid is only lowered when an idle gap actually follows.
    task automatic send_frame(input logic [31:0] delta);
        int gap;
        gap = idle_draw(send_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_frame_delta <= delta;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Frame durations aimed at the interesting spots: zero, all ones, fully random
    // words, tiny values, one tick around a step, and a few steps plus a remainder.
    function automatic logic [31:0] shape_delta(input logic [31:0] step);
        logic [63:0] span;
        case ($urandom_range(0, 9))
            0: shape_delta = '0;
            1: shape_delta = '1;
            2, 3: shape_delta = $urandom;
            4: shape_delta = $urandom_range(0, 255);
            5: shape_delta = step + $urandom_range(0, 2) - 32'd1;
            default: begin
                span = 64'(step) * $urandom_range(0, 4) + (64'($urandom) % (64'(step) + 1));
                shape_delta = span[31:0];
            end
        endcase
    endfunction

    // Result side: waits a drawn number of cycles, then stays ready until a result
    // is taken. Twice in the run it holds off for a long stretch while the sender
    // keeps offering, so the output register and the sequencer both fill and the
    // block stops taking input.
    initial begin : result_sink
        int pause;
        while (!aresetn) @(posedge aclk);
        forever begin
            pause = idle_draw(sink_burst);
            if (results_taken == 100 || results_taken == 1200)
                pause = LONG_HOLD;
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    // Hang detector: any accepted item or register write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fixed_step_accumulator_core_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from the reset settings (step 16667, cap 250000,
        // eight substeps). Zero adds nothing; exactly one step leaves nothing;
        // one tick short takes no step and gives a fraction just under one.
        send_frame(32'd0);
        send_frame(32'd16667);
        send_frame(32'd16666);
        send_frame(32'd8333);
        // All ones hits the cap and drops the rest; the substep limit then leaves
        // more than a step behind, so the fraction saturates. A zero frame after
        // it works off some of that backlog.
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd0);

        // Lower the cap under what is already accumulated: every new tick is
        // dropped and the backlog stays because it is less than one step.
        write_reg(REG_MAX_ACC_TICKS, 32'd1000);
        send_frame(32'd5);
        send_frame(32'hFFFF_FFFF);

        // Step of one tick with the widest substep limit: drain the backlog, then
        // overrun the substep limit so the fraction saturates, then drain again.
        load_settings(32'd1, 32'hFFFF_FFFF, 16'hFFFF);
        send_frame(32'd0);
        send_frame(32'd70000);
        send_frame(32'd0);

        // Step length zero: no steps; the fraction is zero with nothing retained
        // and one as soon as anything is retained.
        write_reg(REG_STEP_TICKS, 32'd0);
        aim_step = 32'd0;
        send_frame(32'd0);
        send_frame(32'd5);
        send_frame(32'd1);

        // Substep limit zero: no steps even with plenty accumulated.
        load_settings(32'd16667, 32'd250000, 16'd0);
        send_frame(32'd40000);
        send_frame(32'd0);

        // Widest settings, and a write to the unused register slot that must
        // change nothing.
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        write_reg(REG_SPARE, $urandom);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd0);
        send_frame(32'hAAAA_AAAA);
        send_frame(32'h5555_5555);

        // Random part: a run of frames under each of several settings.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: load_settings(32'd16667, 32'd250000, 16'd8);
                1: load_settings($urandom_range(1, 64), $urandom_range(64, 5000),
                                 16'($urandom_range(1, 16)));
                2: load_settings(32'd1, 32'hFFFF_FFFF, 16'hFFFF);
                3: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
                4: load_settings($urandom, $urandom, 16'($urandom_range(1, 65535)));
                5: load_settings($urandom_range(1000, 100000), $urandom_range(100000, 2000000),
                                 16'($urandom_range(1, 4)));
                6: load_settings($urandom_range(1, 3), $urandom_range(1, 10),
                                 16'($urandom_range(1, 3)));
                default: load_settings($urandom_range(1, 1 << 20), $urandom,
                                       16'($urandom_range(1, 65535)));
            endcase
            for (int k = 0; k < PHASE_FRAMES; k++)
                send_frame(shape_delta(aim_step));
        end

        // Wrap-up: let every result come home, then give the block time to show
        // any stray result before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && open_results == 0) begin
            $display("fixed_step_accumulator_core_test: clean");
        end else begin
            $display("fixed_step_accumulator_core_test: errors");
        end
        $finish;
    end

endmodule
